// File: rtl/sda_pkg.sv
// ----------------------------------------------------------------------------
// sda_pkg
// shared types and constants of the sector directory allocator
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam int unsigned SectorCountDefault = 40;
  localparam int unsigned ReservedSector     = 16;
  localparam int unsigned LargeFirst         = 32;
  localparam int unsigned LargeLast          = 'h27;
  localparam int unsigned LargeMinWant       = 12 * 16;
  localparam int unsigned LargeBytes         = 15 * 16;
  localparam int unsigned SmallBytes         = 3 * 16;
  localparam int unsigned V1Top              = 'h0f;
  localparam int unsigned V1Stop             = 15;
  localparam int unsigned V2Stop             = 31;

  localparam logic [2:0] CmdLoad  = 3'd0;
  localparam logic [2:0] CmdAlloc = 3'd1;
  localparam logic [2:0] CmdFree  = 3'd2;
  localparam logic [2:0] CmdFind  = 3'd3;
  localparam logic [2:0] CmdCount = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StPresent = 2'd1;
  localparam logic [1:0] StNoSpace = 2'd2;
  localparam logic [1:0] StMissing = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LARGE, S_SMALL, S_COMMIT, S_DONE
  } state_e;

  // one memory access requested by the sequencer
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [5:0]  addr;
    logic [15:0] wdata;
  } mem_req_t;

endpackage

// File: rtl/sda_table.sv
// ----------------------------------------------------------------------------
// sda_table
// sector owner memory, one read or write port, registered read data,
// valid bit per entry so unwritten sectors read as free
// ----------------------------------------------------------------------------
module sda_table import sda_pkg::*; #(
  parameter int unsigned SectorCount = SectorCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mem_req_t    req_i,
  output logic [15:0] rdata_o
);

  logic [15:0]            mem_q [SectorCount];
  logic [SectorCount-1:0] vld_q;
  logic [15:0]            raw_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) mem_q[req_i.addr] <= req_i.wdata;
    if (req_i.rd) raw_q <= mem_q[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr) vld_q[req_i.addr] <= 1'b1;
      if (req_i.rd) rvld_q <= vld_q[req_i.addr];
    end
  end

  assign rdata_o = rvld_q ? raw_q : 16'd0;

endmodule

// File: rtl/sda_ctrl.sv
// ----------------------------------------------------------------------------
// sda_ctrl
// command sequencer: sweeps the table; unless a free write stalls it, reads one sector a cycle
// ----------------------------------------------------------------------------
module sda_ctrl import sda_pkg::*; #(
  parameter int unsigned SectorCount = SectorCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  command_i,
  input  logic [15:0] app_id_i,
  input  logic [15:0] size_bytes_i,
  input  logic [5:0]  target_sector_i,
  input  logic [1:0]  version_i,
  output logic        busy_o,
  output mem_req_t    req_o,
  input  logic [15:0] rdata_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [5:0]  sector_number_o,
  output logic        has_sector_o,
  output logic        last_of_run_o,
  output logic [5:0]  match_count_o
);

  localparam logic [5:0] Cap = 6'(SectorCount - 1);

  function automatic logic [5:0] cap(input logic [5:0] s);
    return (s < 6'(SectorCount)) ? s : Cap;
  endfunction

  state_e              state_q, state_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [15:0]         id_q, id_d;
  logic signed [17:0]  want_q, want_d;
  logic                v1_q, v1_d;
  logic [5:0]          sec_q, sec_d;      // sector of the current sweep step
  logic                pend_q, pend_d;    // read data of sec_q arrives now
  logic [5:0]          cnt_q, cnt_d;
  logic [SectorCount-1:0] take_q, take_d;
  logic                lout_q, lout_d;    // pending found sector in find or commit
  logic [5:0]          lsec_q, lsec_d;

  logic                out_v;
  logic [1:0]          out_st;
  logic [5:0]          out_sec, out_cnt;
  logic                out_has, out_last;
  logic [5:0]          top, stop, ltop;
  logic                hit;

  assign top  = v1_q ? cap(6'(V1Top)) : cap(6'(LargeLast));
  assign stop = v1_q ? cap(6'(V1Stop)) : cap(6'(V2Stop));
  assign ltop = cap(6'(LargeLast));
  assign hit  = (rdata_i == id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      lout_q  <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      lout_q  <= lout_d;
      result_valid_o <= out_v;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; id_q <= id_d; want_q <= want_d; v1_q <= v1_d;
    sec_q <= sec_d; cnt_q <= cnt_d; take_q <= take_d; lsec_q <= lsec_d;
    status_o <= out_st; sector_number_o <= out_sec; has_sector_o <= out_has;
    last_of_run_o <= out_last; match_count_o <= out_cnt;
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; id_d = id_q; want_d = want_q;
    v1_d = v1_q; sec_d = sec_q; pend_d = 1'b0; cnt_d = cnt_q;
    take_d = take_q; lout_d = lout_q; lsec_d = lsec_q;
    req_o = '0;
    out_v = 1'b0; out_st = StOk; out_sec = '0; out_has = 1'b0;
    out_last = 1'b0; out_cnt = '0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = command_i; id_d = app_id_i;
          want_d = 18'(size_bytes_i); v1_d = (version_i == 2'd1);
          cnt_d = '0; take_d = '0; lout_d = 1'b0;
          if (command_i == CmdLoad) begin
            if (target_sector_i < 6'(SectorCount)) begin
              req_o.wr = 1'b1; req_o.addr = target_sector_i;
              req_o.wdata = app_id_i;
            end
            out_v = 1'b1; out_last = 1'b1;
          end else if (command_i == CmdAlloc || command_i == CmdFree ||
                       command_i == CmdFind || command_i == CmdCount) begin
            sec_d = 6'd1; req_o.rd = 1'b1; req_o.addr = 6'd1; pend_d = 1'b1;
            state_d = S_SCAN;
          end else begin
            out_v = 1'b1; out_last = 1'b1;
          end
        end
      end
      // presence, free, find and count sweep over sectors 1..top
      S_SCAN: begin
        if (pend_q) begin
          if (hit) begin
            cnt_d = cnt_q + 6'd1;
            if (cmd_q == CmdFree) begin
              req_o.wr = 1'b1; req_o.addr = sec_q; req_o.wdata = '0;
            end
            if (cmd_q == CmdFind) begin
              // hold one found sector back so the last can be marked
              if (lout_q) begin
                out_v = 1'b1; out_has = 1'b1; out_sec = lsec_q;
              end
              lout_d = 1'b1; lsec_d = sec_q;
            end
          end
          if (sec_q < top && !req_o.wr) begin
            sec_d = sec_q + 6'd1; req_o.rd = 1'b1; req_o.addr = sec_d;
            pend_d = 1'b1;
          end else if (sec_q < top) begin
            sec_d = sec_q + 6'd1; // issue read next cycle
          end else begin
            state_d = S_DONE;
          end
        end else begin
          req_o.rd = 1'b1; req_o.addr = sec_q; pend_d = 1'b1;
        end
      end
      S_DONE: begin
        out_v = 1'b1; out_last = 1'b1;
        state_d = S_IDLE;
        unique case (cmd_q)
          CmdFree:  out_cnt = cnt_q;
          CmdCount: out_cnt = cnt_q;
          CmdFind: begin
            if (lout_q) begin out_has = 1'b1; out_sec = lsec_q; end
            else out_st = StMissing;
          end
          CmdAlloc: begin
            if (cnt_q != '0) begin
              out_st = StPresent;
            end else if (!v1_q && 6'(LargeFirst) < 6'(SectorCount)) begin
              out_v = 1'b0; out_last = 1'b0; state_d = S_LARGE;
              sec_d = 6'(LargeFirst); req_o.rd = 1'b1;
              req_o.addr = 6'(LargeFirst); pend_d = 1'b1;
            end else begin
              out_v = 1'b0; out_last = 1'b0; state_d = S_SMALL;
              sec_d = 6'd1; req_o.rd = 1'b1; req_o.addr = 6'd1; pend_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_LARGE: begin
        if (want_q < 18'sd192) begin
          state_d = S_SMALL; sec_d = 6'd1; req_o.rd = 1'b1;
          req_o.addr = 6'd1; pend_d = 1'b1;
        end else begin
          if (rdata_i == 16'd0) begin
            take_d[sec_q] = 1'b1; want_d = want_q - 18'(LargeBytes);
          end
          if (sec_q < ltop) begin
            sec_d = sec_q + 6'd1; req_o.rd = 1'b1; req_o.addr = sec_d;
            pend_d = 1'b1;
          end else begin
            state_d = S_SMALL; sec_d = 6'd1; req_o.rd = 1'b1;
            req_o.addr = 6'd1; pend_d = 1'b1;
          end
        end
      end
      S_SMALL: begin
        if (want_q <= 18'sd0 || sec_q > stop) begin
          if (want_q > 18'sd0) begin
            out_v = 1'b1; out_last = 1'b1; out_st = StNoSpace;
            state_d = S_IDLE;
          end else begin
            state_d = S_COMMIT; sec_d = 6'd1; lout_d = 1'b0;
          end
        end else begin
          if (sec_q != 6'(ReservedSector) && rdata_i == 16'd0) begin
            take_d[sec_q] = 1'b1; want_d = want_q - 18'(SmallBytes);
          end
          sec_d = sec_q + 6'd1; req_o.rd = 1'b1; req_o.addr = sec_d;
          pend_d = 1'b1;
        end
      end
      // write owned sectors, one result each, last one held back
      S_COMMIT: begin
        if (take_q[sec_q[$clog2(SectorCount)-1:0]]) begin
          req_o.wr = 1'b1; req_o.addr = sec_q; req_o.wdata = id_q;
          if (lout_q) begin out_v = 1'b1; out_has = 1'b1; out_sec = lsec_q; end
          lout_d = 1'b1; lsec_d = sec_q;
        end
        if (sec_q < Cap) begin
          sec_d = sec_q + 6'd1;
        end else begin
          out_v = 1'b1; out_last = 1'b1; state_d = S_IDLE;
          if (take_q[sec_q[$clog2(SectorCount)-1:0]]) begin
            out_has = 1'b1; out_sec = sec_q;
            if (lout_q) begin out_v = 1'b1; end
          end else if (lout_q) begin
            out_has = 1'b1; out_sec = lsec_q;
          end
          if (take_q[sec_q[$clog2(SectorCount)-1:0]] && lout_q) begin
            // two results would collide: send the held one now, this one from S_DONE next cycle
            out_last = 1'b0; out_sec = lsec_q; lout_d = 1'b1; lsec_d = sec_q;
            state_d = S_DONE; cmd_d = CmdFind;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_o.rd && req_o.wr)) else $error("read and write in one cycle");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |-> !req_o.wr)
    else $error("write while idle");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmd_q != CmdAlloc) |=> (result_valid_o && last_of_run_o))
    else $error("missing final result");

endmodule

// File: rtl/sector_directory_allocator.sv
// ----------------------------------------------------------------------------
// sector_directory_allocator
// application directory: per-sector owner ids with allocate, free, find, count
// ----------------------------------------------------------------------------
// sequence: load writes one sector straight from idle; find, count, free sweep
// 1..top, a free stalling the sweep per freed sector; allocate sweeps 1..top,
// large pass 32..39 (not version 1), small pass, commit up to the last sector
// throughput: one command at a time, the next is taken once busy falls
// results leave on a one-cycle strobe, the receiver cannot stall
// reset: version 1, all sectors free at once through per-entry valid bits
module sector_directory_allocator import sda_pkg::*; #(
  parameter int unsigned SectorCount = SectorCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [15:0] app_id_i,
  input  logic [15:0] size_bytes_i,
  input  logic [5:0]  target_sector_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [5:0]  sector_number_o,
  output logic        has_sector_o,
  output logic        last_of_run_o,
  output logic [5:0]  match_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  version_q;
  mem_req_t    req;
  logic [15:0] rdata;

  // config register at byte address 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= 2'd1;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      version_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, version_q} : 32'd0;

  sda_ctrl #(.SectorCount(SectorCount)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .command_i, .app_id_i, .size_bytes_i,
    .target_sector_i, .version_i(version_q), .busy_o(busy), .req_o(req),
    .rdata_i(rdata), .result_valid_o, .status_o, .sector_number_o,
    .has_sector_o, .last_of_run_o, .match_count_o
  );

  sda_table #(.SectorCount(SectorCount)) u_table (
    .clk_i, .rst_ni, .req_i(req), .rdata_o(rdata)
  );

endmodule

// File: verif/sector_directory_allocator_tb.sv
// ----------------------------------------------------------------------------
// sector_directory_allocator_tb
// checks every command of the sector directory against a behavioral predictor
// ----------------------------------------------------------------------------
// a short directed table runs first, then random command streams on every
// directory version; each result transfer is compared field by field with
// the oldest predicted result
`timescale 1ns / 100ps

module sector_directory_allocator_tb import sda_pkg::*;;

  localparam int unsigned NumSectors = SectorCountDefault;

  typedef struct {
    logic [1:0] status;
    logic [5:0] sector;
    logic       has_sector;
    logic       last;
    logic [5:0] count;
  } dir_result_t;

  // directed row: cfg rows write size as the directory version
  typedef struct {
    bit          cfg;
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [15:0] size;
    logic [5:0]  tgt;
    bit          typed;
    logic [1:0]  status;
    logic [5:0]  count;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command_i = CmdLoad;
  logic [15:0] app_id_i = '0;
  logic [15:0] size_bytes_i = '0;
  logic [5:0]  target_sector_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [5:0]  sector_number_o;
  logic        has_sector_o;
  logic        last_of_run_o;
  logic [5:0]  match_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [15:0]  owner_tbl [NumSectors];
  logic [1:0]   dir_version;
  dir_result_t  pending_results[$];
  int unsigned  fail_cnt = 0;

  sector_directory_allocator dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("sector_directory_allocator: mismatch");
    $finish;
  end

  function automatic int unsigned scan_limit();
    return (dir_version == 2'd1) ? V1Top : LargeLast;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [5:0] sec, logic has,
                                      logic last, logic [5:0] cnt);
    dir_result_t r;
    r.status = st;
    r.sector = sec;
    r.has_sector = has;
    r.last = last;
    r.count = cnt;
    pending_results.push_back(r);
  endfunction

  // updates the owner table and queues the results of one command
  function automatic void apply_directory_command(logic [2:0] cmd, logic [15:0] id,
                                                  logic [15:0] size, logic [5:0] tgt);
    int unsigned top;
    int unsigned hits;
    int unsigned stop;
    int          want;
    bit          take [NumSectors];
    top = scan_limit();
    hits = 0;
    for (int unsigned s = 1; s <= top; s++) if (owner_tbl[s] == id) hits++;
    case (cmd)
      CmdLoad: begin
        if (tgt < NumSectors) owner_tbl[tgt] = id;
        push_result(StOk, 0, 0, 1, 0);
      end
      CmdAlloc: begin
        if (hits != 0) begin
          push_result(StPresent, 0, 0, 1, 0);
          return;
        end
        want = int'(size);
        foreach (take[s]) take[s] = 0;
        // large sectors only pay off while a big chunk is still wanted
        if (dir_version != 2'd1) begin
          for (int unsigned s = LargeFirst; s <= LargeLast && want >= int'(LargeMinWant);
               s++) begin
            if (owner_tbl[s] == 0) begin
              take[s] = 1;
              want -= LargeBytes;
            end
          end
        end
        stop = (dir_version == 2'd1) ? V1Stop : V2Stop;
        for (int unsigned s = 1; s <= stop && want > 0; s++) begin
          if (s != ReservedSector && owner_tbl[s] == 0) begin
            take[s] = 1;
            want -= SmallBytes;
          end
        end
        if (want > 0) begin
          push_result(StNoSpace, 0, 0, 1, 0);
          return;
        end
        hits = 0;
        for (int unsigned s = 1; s < NumSectors; s++) begin
          if (take[s]) begin
            owner_tbl[s] = id;
            push_result(StOk, s[5:0], 1, 0, 0);
            hits++;
          end
        end
        if (hits == 0) push_result(StOk, 0, 0, 1, 0);
        else pending_results[$].last = 1;
      end
      CmdFree: begin
        for (int unsigned s = 1; s <= top; s++) if (owner_tbl[s] == id) owner_tbl[s] = 0;
        push_result(StOk, 0, 0, 1, hits[5:0]);
      end
      CmdFind: begin
        for (int unsigned s = 1; s <= top; s++)
          if (owner_tbl[s] == id) push_result(StOk, s[5:0], 1, 0, 0);
        if (hits == 0) push_result(StMissing, 0, 0, 1, 0);
        else pending_results[$].last = 1;
      end
      CmdCount: push_result(StOk, 0, 0, 1, hits[5:0]);
      default:  push_result(StOk, 0, 0, 1, 0);
    endcase
  endfunction

  // result monitor: strobes cannot be stalled, so every valid cycle is a transfer
  always @(posedge clk_i) begin
    dir_result_t want_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d sec=%0d has=%0d last=%0d cnt=%0d",
                 $time, status_o, sector_number_o, has_sector_o, last_of_run_o,
                 match_count_o);
        fail_cnt++;
      end else begin
        want_r = pending_results.pop_front();
        if (status_o !== want_r.status || sector_number_o !== want_r.sector ||
            has_sector_o !== want_r.has_sector || last_of_run_o !== want_r.last ||
            match_count_o !== want_r.count) begin
          $display("%0t: expected st=%0d sec=%0d has=%0d last=%0d cnt=%0d", $time,
                   want_r.status, want_r.sector, want_r.has_sector, want_r.last,
                   want_r.count);
          $display("%0t: actual   st=%0d sec=%0d has=%0d last=%0d cnt=%0d", $time,
                   status_o, sector_number_o, has_sector_o, last_of_run_o, match_count_o);
          fail_cnt++;
        end
      end
    end
  end

  // drives one command and returns at the edge where it was taken
  task automatic issue(logic [2:0] cmd, logic [15:0] id, logic [15:0] size,
                       logic [5:0] tgt);
    start <= 1'b1;
    command_i <= cmd;
    app_id_i <= id;
    size_bytes_i <= size;
    target_sector_i <= tgt;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // let every outstanding result arrive and the sequencer settle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_version(logic [1:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= 32'(v);
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    dir_version = v;
    // read back through the same port
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(v)) begin
      $display("%0t: expected version %0d, actual %0d", $time, v, prdata);
      fail_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  dir_row_t dir_rows [25] = '{
    '{0, CmdCount, 16'h0000, 16'd0,     6'd0,  1, StOk,      6'd15},
    '{0, CmdFind,  16'h1234, 16'd0,     6'd0,  1, StMissing, 6'd0},
    '{0, CmdAlloc, 16'h1234, 16'd0,     6'd0,  1, StOk,      6'd0},
    '{0, CmdAlloc, 16'h0000, 16'd10,    6'd0,  1, StPresent, 6'd0},
    '{0, CmdAlloc, 16'hffff, 16'hffff,  6'd0,  1, StNoSpace, 6'd0},
    '{0, CmdLoad,  16'hffff, 16'd0,     6'd63, 1, StOk,      6'd0},
    '{0, CmdLoad,  16'haaaa, 16'd0,     6'd0,  1, StOk,      6'd0},
    '{0, CmdLoad,  16'h5555, 16'd0,     6'd39, 1, StOk,      6'd0},
    '{0, CmdAlloc, 16'h0101, 16'd100,   6'd0,  0, StOk,      6'd0},
    '{0, CmdFind,  16'h0101, 16'd0,     6'd0,  0, StOk,      6'd0},
    '{0, CmdCount, 16'h0101, 16'd0,     6'd0,  0, StOk,      6'd0},
    '{0, CmdAlloc, 16'h0101, 16'd1,     6'd0,  1, StPresent, 6'd0},
    '{0, CmdFree,  16'h0101, 16'd0,     6'd0,  0, StOk,      6'd0},
    '{0, 3'd5,     16'h0001, 16'd1,     6'd1,  1, StOk,      6'd0},
    '{0, 3'd6,     16'h0001, 16'd1,     6'd1,  1, StOk,      6'd0},
    '{0, 3'd7,     16'hffff, 16'hffff,  6'd63, 1, StOk,      6'd0},
    '{0, CmdAlloc, 16'h0202, 16'd720,   6'd0,  0, StOk,      6'd0},
    '{0, CmdFree,  16'h0202, 16'd0,     6'd0,  0, StOk,      6'd0},
    '{1, CmdLoad,  16'h0000, 16'd2,     6'd0,  0, StOk,      6'd0},
    '{0, CmdAlloc, 16'h0303, 16'hffff,  6'd0,  1, StNoSpace, 6'd0},
    '{0, CmdAlloc, 16'h0404, 16'd500,   6'd0,  0, StOk,      6'd0},
    '{0, CmdFree,  16'h0404, 16'd0,     6'd0,  0, StOk,      6'd0},
    '{0, CmdAlloc, 16'h0505, 16'd3360,  6'd0,  0, StOk,      6'd0},
    '{0, CmdFind,  16'h0505, 16'd0,     6'd0,  0, StOk,      6'd0},
    '{0, CmdFree,  16'h0505, 16'd0,     6'd0,  0, StOk,      6'd0}
  };

  initial begin
    logic [1:0]  phase_version [5];
    int unsigned idle_pct [5];
    logic [15:0] id_pool [6];
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [15:0] size;
    logic [5:0]  tgt;
    int unsigned pick;
    int unsigned qlen;

    phase_version = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2};
    idle_pct = '{7, 75, 0, 7, 75};
    foreach (owner_tbl[s]) owner_tbl[s] = '0;
    dir_version = 2'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        drain();
        write_version(dir_rows[i].size[1:0]);
      end else begin
        issue(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].size, dir_rows[i].tgt);
        qlen = pending_results.size();
        apply_directory_command(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].size,
                                dir_rows[i].tgt);
        if (dir_rows[i].typed) begin
          // the typed row replaces what the predictor queued
          while (pending_results.size() > qlen) void'(pending_results.pop_back());
          push_result(dir_rows[i].status, 0, 0, 1, dir_rows[i].count);
        end
      end
    end

    // random phases, each with the version and idle rate of its table entry
    for (int p = 0; p < 5; p++) begin
      drain();
      write_version(phase_version[p]);
      foreach (id_pool[k]) id_pool[k] = 16'($urandom_range(1, 16'hffff));
      for (int n = 0; n < 58; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) id = id_pool[$urandom_range(0, 5)];
        else if (pick < 80) id = 16'h0000;
        else if (pick < 90) id = 16'hffff;
        else id = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) size = 16'($urandom_range(0, 600));
        else if (pick < 90) size = 16'($urandom_range(600, 3400));
        else size = 16'($urandom);
        tgt = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 39));
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = CmdAlloc;
        else if (pick < 50) cmd = CmdFree;
        else if (pick < 65) cmd = CmdFind;
        else if (pick < 75) cmd = CmdCount;
        else if (pick < 94) cmd = CmdLoad;
        else cmd = 3'($urandom_range(5, 7));
        issue(cmd, id, size, tgt);
        apply_directory_command(cmd, id, size, tgt);
        if (n == 29) begin
          // hold the next command until the directory has answered everything
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end else if ($urandom_range(0, 99) < idle_pct[p]) begin
          idle_cycles($urandom_range(1, 6));
        end
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("sector_directory_allocator: match");
    end else begin
      $display("sector_directory_allocator: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sda_pkg.sv
rtl/sda_table.sv
rtl/sda_ctrl.sv
rtl/sector_directory_allocator.sv
verif/sector_directory_allocator_tb.sv
